// ===== rtl/lcpd_pkg.sv =====
// Package for the length-class prefix decoder.
// Holds field widths, phase and sequencer types and bit-window helpers.
// No dependencies.
`default_nettype none

package lcpd_pkg;

    localparam int WORD_BITS     = 32;
    localparam int VALUE_BITS    = 31;
    localparam int LEN_FIELD     = 4;
    localparam int IDX_FIELD     = 5;
    localparam int MAX_CODE_BITS = 9;
    localparam int NUM_CLASSES   = 32;
    localparam int MAX_OUT       = 32;
    localparam int ENTRY_BITS    = MAX_CODE_BITS + LEN_FIELD;
    localparam int CLASS_BITS    = $clog2(NUM_CLASSES);
    localparam int WIN_BITS      = 2 * WORD_BITS;
    localparam int HELD_BITS     = $clog2(WIN_BITS + 1);
    localparam int NRES_BITS     = $clog2(MAX_OUT + 1);
    localparam int SCAN_BITS     = $clog2(NUM_CLASSES + 1);
    localparam int FIELD_MAX     = IDX_FIELD + ENTRY_BITS;

    // stream position within a block
    typedef enum logic [2:0] {
        PH_COUNT  = 3'd0,
        PH_HEAD   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_ENTRY  = 3'd3,
        PH_PREFIX = 3'd4,
        PH_EXTRA  = 3'd5
    } t_phase;

    // sequencer for one input word
    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_STEP   = 3'd1,
        S_SCAN   = 3'd2,
        S_DECIDE = 3'd3,
        S_FIN    = 3'd4
    } t_seq;

    // top n bits of a 32-bit slice, right aligned; zero when n is zero
    function automatic logic [31:0] lcpd_peek(input logic [31:0] top, input logic [5:0] n);
        logic [31:0] r;
        r = 32'd0;
        if (n != 6'd0) begin
            r = top >> (6'd32 - n);
        end
        return r;
    endfunction

    // low n bits set
    function automatic logic [FIELD_MAX-1:0] lcpd_mask(input logic [5:0] n);
        logic [FIELD_MAX-1:0] r;
        r = ({{(FIELD_MAX-1){1'b0}}, 1'b1} << n) - {{(FIELD_MAX-1){1'b0}}, 1'b1};
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lcpd_word_if.sv =====
// Input channel of the decoder: one compressed 32-bit word per transaction.
// Depends on lcpd_pkg.
`default_nettype none

interface lcpd_word_if import lcpd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

// ===== rtl/lcpd_res_if.sv =====
// Output channel of the decoder: one decoded result per transaction.
// Depends on lcpd_pkg.
`default_nettype none

interface lcpd_res_if import lcpd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  run_last;
    logic                  block_done;
    logic                  error;

    modport source (output valid, output value, output run_last, output block_done,
                    output error, input ready);
    modport sink   (input valid, input value, input run_last, input block_done,
                    input error, output ready);
endinterface

`default_nettype wire

// ===== rtl/length_class_prefix_decoder_unit.sv =====
// Top level of the length-class prefix decoder.
// Depends on lcpd_pkg, lcpd_word_if and lcpd_res_if.
//
// A count word is taken in the idle state. A data word is loaded and then
// decoded in steps: one per header field or extra-bit field, and for each prefix
// symbol a scan of the 32-entry code memory at one entry per cycle and a
// decision; a step that runs short of bits goes to the close. Steps and decisions
// hold while a staged result cannot move on. A result is staged until the next
// result or the close shows whether it is the last, and only then moves to the
// output register. Reset is synchronous and clears all control state; code memory
// contents are masked by per-entry valid bits.
`default_nettype none

module length_class_prefix_decoder_unit import lcpd_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    lcpd_word_if.sink    i_in,
    lcpd_res_if.source   o_out
);

    t_seq                    r_seq, n_seq;
    t_phase                  r_phase, n_phase;
    logic [WIN_BITS-1:0]     r_win, n_win;
    logic [HELD_BITS-1:0]    r_held, n_held;
    logic [31:0]             r_vleft, n_vleft;
    logic [3:0]              r_maxlen, n_maxlen;
    logic [CLASS_BITS-1:0]   r_cleft, n_cleft;
    logic [CLASS_BITS-1:0]   r_pclass, n_pclass;
    logic [NUM_CLASSES-1:0]  r_valid, n_valid;
    logic [NRES_BITS-1:0]    r_nres, n_nres;
    logic [SCAN_BITS-1:0]    r_scan, n_scan;
    logic [CLASS_BITS-1:0]   r_cidx;
    logic                    r_cvalid;
    logic                    r_sure_v, n_sure_v;
    logic [CLASS_BITS-1:0]   r_sure, n_sure;
    logic [3:0]              r_sure_len, n_sure_len;
    logic                    r_may_v, n_may_v;
    logic [CLASS_BITS-1:0]   r_may, n_may;

    // staged result and output register
    logic                    r_pv, n_pv;
    logic [VALUE_BITS-1:0]   r_pval, n_pval;
    logic                    r_pdone, n_pdone;
    logic                    r_perr, n_perr;
    logic                    r_ov, n_ov;
    logic [VALUE_BITS-1:0]   r_oval, n_oval;
    logic                    r_olast, n_olast;
    logic                    r_odone, n_odone;
    logic                    r_oerr, n_oerr;

    // code memory
    logic [ENTRY_BITS-1:0]   r_mem [NUM_CLASSES];
    logic [ENTRY_BITS-1:0]   r_rdata;
    logic                    w_we;
    logic [CLASS_BITS-1:0]   w_waddr;
    logic [ENTRY_BITS-1:0]   w_wdata;

    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_go;
    logic                    w_fin;
    logic                    w_scan;
    logic                    w_res;
    logic [VALUE_BITS-1:0]   w_res_val;
    logic                    w_res_done;
    logic                    w_res_err;
    logic [31:0]             w_top;
    logic [5:0]              w_need;
    logic [31:0]             w_pk;
    logic [FIELD_MAX-1:0]    w_fx;
    logic [CLASS_BITS-1:0]   w_cl;
    logic [31:0]             w_vdec;
    logic [5:0]              w_ml4;
    logic [3:0]              w_hh;
    logic [31:0]             w_kpk;
    logic [MAX_CODE_BITS-1:0] w_known;
    logic [3:0]              w_elen;
    logic [MAX_CODE_BITS-1:0] w_ecode;
    logic                    w_hit_sure;
    logic                    w_hit_may;
    logic                    w_wait;
    logic [HELD_BITS-1:0]    w_hkeep;
    logic [WIN_BITS-1:0]     w_wkeep;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ov || o_out.ready;
    assign w_go       = !r_pv || w_out_free;
    assign w_top      = r_win[WIN_BITS-1 -: 32];
    assign w_ml4      = {2'b00, r_maxlen} + 6'd4;
    assign w_vdec     = r_vleft - 32'd1;

    assign i_in.ready       = (r_seq == S_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.value      = r_oval;
    assign o_out.run_last   = r_olast;
    assign o_out.block_done = r_odone;
    assign o_out.error      = r_oerr;

    // compare the entry read last cycle against the held prefix bits
    always_comb begin
        w_hh       = (r_held < {3'b000, r_maxlen}) ? r_held[3:0] : r_maxlen;
        w_kpk      = lcpd_peek(w_top, {2'b00, w_hh});
        w_known    = w_kpk[MAX_CODE_BITS-1:0];
        w_elen     = r_rdata[3:0];
        w_ecode    = r_rdata[ENTRY_BITS-1:LEN_FIELD];
        w_hit_sure = 1'b0;
        w_hit_may  = 1'b0;
        if (r_cvalid && r_valid[r_cidx] && (w_elen != 4'd0) && (w_elen <= r_maxlen)) begin
            if (w_elen <= w_hh) begin
                w_hit_sure = ((w_known >> (w_hh - w_elen)) == w_ecode);
            end else begin
                w_hit_may = ((w_ecode >> (w_elen - w_hh)) == w_known);
            end
        end
    end

    // a candidate still open outranks the sure match if its class is higher or there is none
    assign w_wait = r_may_v && (!r_sure_v || (r_may > r_sure));

    // window after dropping excess bits ahead of an append
    assign w_hkeep = (r_held > HELD_BITS'(32)) ? HELD_BITS'(32) : r_held;
    assign w_wkeep = (r_held > HELD_BITS'(32)) ? (r_win << (r_held - HELD_BITS'(32))) : r_win;

    // datapath: one decode step per cycle while the staged result can move on
    always_comb begin
        n_phase    = r_phase;
        n_win      = r_win;
        n_held     = r_held;
        n_vleft    = r_vleft;
        n_maxlen   = r_maxlen;
        n_cleft    = r_cleft;
        n_pclass   = r_pclass;
        n_valid    = r_valid;
        n_nres     = r_nres;
        n_scan     = r_scan;
        n_sure_v   = r_sure_v;
        n_sure     = r_sure;
        n_sure_len = r_sure_len;
        n_may_v    = r_may_v;
        n_may      = r_may;
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wdata    = '0;
        w_fin      = 1'b0;
        w_scan     = 1'b0;
        w_res      = 1'b0;
        w_res_val  = '0;
        w_res_done = 1'b0;
        w_res_err  = 1'b0;
        w_need     = 6'd0;
        w_pk       = 32'd0;
        w_fx       = '0;
        w_cl       = '0;

        case (r_seq)
            S_IDLE: begin
                if (w_accept) begin
                    n_nres = '0;
                    if (r_phase == PH_COUNT) begin
                        n_vleft  = i_in.word;
                        n_valid  = '0;
                        n_win    = '0;
                        n_held   = '0;
                        n_cleft  = '0;
                        n_pclass = '0;
                        n_phase  = PH_HEAD;
                    end else begin
                        n_win  = w_wkeep | ({i_in.word, 32'd0} >> w_hkeep);
                        n_held = w_hkeep + HELD_BITS'(32);
                    end
                end
            end
            S_STEP: begin
                if (w_go) begin
                    case (r_phase)
                        PH_HEAD: begin
                            w_need = 6'(LEN_FIELD + IDX_FIELD);
                            if (r_held < HELD_BITS'(w_need)) begin
                                w_fin = 1'b1;
                            end else begin
                                w_pk   = lcpd_peek(w_top, w_need);
                                n_win  = r_win << w_need;
                                n_held = r_held - HELD_BITS'(w_need);
                                if (w_pk[8:5] > 4'(MAX_CODE_BITS)) begin
                                    w_res      = 1'b1;
                                    w_res_done = 1'b1;
                                    w_res_err  = 1'b1;
                                end else begin
                                    n_maxlen = w_pk[8:5];
                                    n_cleft  = w_pk[4:0];
                                    n_phase  = PH_ZERO;
                                end
                            end
                        end
                        PH_ZERO, PH_ENTRY: begin
                            w_need = (r_phase == PH_ZERO) ? w_ml4 : w_ml4 + 6'(IDX_FIELD);
                            if (r_held < HELD_BITS'(w_need)) begin
                                w_fin = 1'b1;
                            end else begin
                                w_pk    = lcpd_peek(w_top, w_need);
                                w_fx    = w_pk[FIELD_MAX-1:0];
                                n_win   = r_win << w_need;
                                n_held  = r_held - HELD_BITS'(w_need);
                                w_we    = 1'b1;
                                w_wdata = ENTRY_BITS'(w_fx & lcpd_mask(w_ml4));
                                w_waddr = (r_phase == PH_ZERO) ? '0
                                          : CLASS_BITS'(w_fx >> w_ml4);
                                n_valid[w_waddr] = 1'b1;
                                w_cl    = (r_cleft != '0) ? r_cleft - 1'b1 : '0;
                                n_cleft = w_cl;
                                if ((r_phase == PH_ZERO) && (w_cl != '0)) begin
                                    n_phase = PH_ENTRY;
                                end else if (w_cl == '0) begin
                                    if (r_vleft == 32'd0) begin
                                        w_fin = 1'b1;
                                    end else begin
                                        n_phase = PH_PREFIX;
                                    end
                                end
                            end
                        end
                        PH_PREFIX: begin
                            w_scan   = 1'b1;
                            n_scan   = '0;
                            n_sure_v = 1'b0;
                            n_may_v  = 1'b0;
                        end
                        PH_EXTRA: begin
                            w_need = {1'b0, r_pclass - 1'b1};
                            if (r_held < HELD_BITS'(w_need)) begin
                                w_fin = 1'b1;
                            end else begin
                                w_pk       = lcpd_peek(w_top, w_need) | (32'd1 << w_need);
                                n_win      = r_win << w_need;
                                n_held     = r_held - HELD_BITS'(w_need);
                                n_phase    = PH_PREFIX;
                                n_vleft    = w_vdec;
                                w_res      = 1'b1;
                                w_res_val  = w_pk[VALUE_BITS-1:0];
                                w_res_done = (w_vdec == 32'd0);
                            end
                        end
                        default: begin
                            w_fin = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_scan != SCAN_BITS'(NUM_CLASSES)) begin
                    n_scan = r_scan + 1'b1;
                end
                if (w_hit_sure) begin
                    n_sure_v   = 1'b1;
                    n_sure     = r_cidx;
                    n_sure_len = w_elen;
                end
                if (w_hit_may) begin
                    n_may_v = 1'b1;
                    n_may   = r_cidx;
                end
            end
            S_DECIDE: begin
                if (w_go) begin
                    if (w_wait) begin
                        w_fin = 1'b1;
                    end else if (!r_sure_v) begin
                        w_res      = 1'b1;
                        w_res_done = 1'b1;
                        w_res_err  = 1'b1;
                    end else begin
                        n_win  = r_win << r_sure_len;
                        n_held = r_held - HELD_BITS'(r_sure_len);
                        if (r_sure == '0) begin
                            n_vleft    = w_vdec;
                            w_res      = 1'b1;
                            w_res_done = (w_vdec == 32'd0);
                        end else begin
                            n_pclass = r_sure;
                            n_phase  = PH_EXTRA;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // count results (word ends at limit); close block when done or on error
        if (w_res) begin
            n_nres = r_nres + 1'b1;
            if (r_nres == NRES_BITS'(MAX_OUT - 1)) begin
                w_fin = 1'b1;
            end
        end
        if ((w_res && w_res_done) || (w_fin && (r_seq == S_STEP) && (r_phase != PH_HEAD)
            && (r_phase != PH_EXTRA) && (r_phase != PH_PREFIX)
            && (r_held >= HELD_BITS'(w_need)))) begin
            n_win    = '0;
            n_held   = '0;
            n_phase  = PH_COUNT;
            n_vleft  = '0;
            n_cleft  = '0;
            n_pclass = '0;
            w_fin    = 1'b1;
        end
    end

    // staging: hold a result until the next result or the close shows if it is last
    always_comb begin
        n_pv    = r_pv;
        n_pval  = r_pval;
        n_pdone = r_pdone;
        n_perr  = r_perr;
        n_ov    = r_ov && !o_out.ready;
        n_oval  = r_oval;
        n_olast = r_olast;
        n_odone = r_odone;
        n_oerr  = r_oerr;
        if (w_res) begin
            if (r_pv) begin
                n_ov    = 1'b1;
                n_oval  = r_pval;
                n_olast = 1'b0;
                n_odone = r_pdone;
                n_oerr  = r_perr;
            end
            n_pv    = 1'b1;
            n_pval  = w_res_val;
            n_pdone = w_res_done;
            n_perr  = w_res_err;
        end else if ((r_seq == S_FIN) && r_pv && w_out_free) begin
            n_ov    = 1'b1;
            n_oval  = r_pval;
            n_olast = 1'b1;
            n_odone = r_pdone;
            n_oerr  = r_perr;
            n_pv    = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            S_IDLE: begin
                if (w_accept && (r_phase != PH_COUNT)) begin
                    n_seq = S_STEP;
                end
            end
            S_STEP: begin
                if (w_go) begin
                    if (w_scan) begin
                        n_seq = S_SCAN;
                    end else if (w_fin) begin
                        n_seq = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                if (r_scan == SCAN_BITS'(NUM_CLASSES)) begin
                    n_seq = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_go) begin
                    n_seq = w_fin ? S_FIN : S_STEP;
                end
            end
            S_FIN: begin
                if (!r_pv || w_out_free) begin
                    n_seq = S_IDLE;
                end
            end
            default: begin
                n_seq = S_IDLE;
            end
        endcase
    end

    // code memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_scan[CLASS_BITS-1:0]];
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= S_IDLE;
            r_phase    <= PH_COUNT;
            r_win      <= '0;
            r_held     <= '0;
            r_vleft    <= '0;
            r_maxlen   <= '0;
            r_cleft    <= '0;
            r_pclass   <= '0;
            r_valid    <= '0;
            r_nres     <= '0;
            r_scan     <= '0;
            r_cvalid   <= 1'b0;
            r_sure_v   <= 1'b0;
            r_may_v    <= 1'b0;
            r_pv       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_seq      <= n_seq;
            r_phase    <= n_phase;
            r_win      <= n_win;
            r_held     <= n_held;
            r_vleft    <= n_vleft;
            r_maxlen   <= n_maxlen;
            r_cleft    <= n_cleft;
            r_pclass   <= n_pclass;
            r_valid    <= n_valid;
            r_nres     <= n_nres;
            r_scan     <= n_scan;
            r_cvalid   <= (r_seq == S_SCAN) && (r_scan != SCAN_BITS'(NUM_CLASSES));
            r_sure_v   <= n_sure_v;
            r_may_v    <= n_may_v;
            r_pv       <= n_pv;
            r_ov       <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cidx     <= r_scan[CLASS_BITS-1:0];
        r_sure     <= n_sure;
        r_sure_len <= n_sure_len;
        r_may      <= n_may;
        r_pval     <= n_pval;
        r_pdone    <= n_pdone;
        r_perr     <= n_perr;
        r_oval     <= n_oval;
        r_olast    <= n_olast;
        r_odone    <= n_odone;
        r_oerr     <= n_oerr;
    end

    // checks
    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= NRES_BITS'(MAX_OUT))
        else $error("result count above limit");

    a_idle_no_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == S_IDLE) |-> !r_pv)
        else $error("staged result left behind at idle");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HELD_BITS'(WIN_BITS))
        else $error("bit window overfilled");

    a_count_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == S_IDLE && r_phase == PH_COUNT) |-> (r_held == '0))
        else $error("bits held while awaiting count word");

    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == S_FIN && !r_pv) |=> (r_seq == S_IDLE))
        else $error("close of word did not return to idle");

endmodule

`default_nettype wire

// ===== sim/length_class_prefix_decoder_unit_tb.sv =====
// Self-checking testbench for length_class_prefix_decoder_unit.
// Depends on lcpd_pkg, lcpd_word_if and lcpd_res_if; builds compressed blocks,
// predicts every decoded value and checks the result stream in order.
`timescale 1ns / 1ps

module length_class_prefix_decoder_unit_tb;
    import lcpd_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2500;
    localparam int WORD_TARGET = 380;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic                  run_last;
        logic                  block_done;
        logic                  error;
    } t_result;

    typedef struct {
        logic [WORD_BITS-1:0] word;
        bit                   drain;
    } t_word_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lcpd_word_if in_if ();
    lcpd_res_if  out_if ();

    length_class_prefix_decoder_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    always #1 i_clk = ~i_clk;

    // decoder state as the predictor sees it
    logic [63:0]   win_bits;
    int unsigned   win_cnt;
    t_phase        stream_ph;
    int unsigned   vals_left;
    int unsigned   code_len_max;
    int unsigned   entries_left;
    logic [12:0]   class_code [NUM_CLASSES];
    int unsigned   extra_class;

    t_result       expected_q [$];
    t_word_item    word_q [$];
    bit            stream_bits [$];
    int            fail_cnt = 0;
    int            res_cnt = 0;
    int            idle_cnt = 0;

    function automatic logic [63:0] low_ones(input int unsigned n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic logic [31:0] window_top(input int unsigned n);
        if (n == 0 || n > win_cnt || n > 32) return 32'd0;
        return 32'((win_bits >> (win_cnt - n)) & low_ones(n));
    endfunction

    function automatic void window_drop(input int unsigned n);
        if (n > win_cnt) n = win_cnt;
        win_cnt -= n;
        win_bits &= low_ones(win_cnt);
    endfunction

    function automatic void close_block();
        win_bits = '0;
        win_cnt = 0;
        stream_ph = PH_COUNT;
        vals_left = 0;
        entries_left = 0;
        extra_class = 0;
    endfunction

    // header done: start symbols, or close an empty block
    function automatic bit open_symbols();
        if (vals_left == 0) begin
            close_block();
            return 1'b0;
        end
        stream_ph = PH_PREFIX;
        return 1'b1;
    endfunction

    // work out the results that one accepted word causes
    function automatic void decode_word(input logic [31:0] w);
        t_result     outs [$];
        t_result     r;
        bit          run;
        int unsigned m, hh, need, len, code;
        logic [31:0] x, known, v;
        int          sure, may;
        run = 1'b1;
        if (stream_ph == PH_COUNT || stream_ph > PH_EXTRA) begin
            close_block();
            vals_left = w;
            for (int c = 0; c < NUM_CLASSES; c++) class_code[c] = '0;
            stream_ph = PH_HEAD;
            return;
        end
        if (win_cnt > 32) window_drop(win_cnt - 32);
        win_bits = (win_bits << WORD_BITS) | 64'(w);
        win_cnt += WORD_BITS;
        while (run && outs.size() < MAX_OUT) begin
            m = code_len_max;
            r = '{value: '0, run_last: 1'b0, block_done: 1'b0, error: 1'b0};
            if (stream_ph == PH_HEAD) begin
                if (win_cnt < LEN_FIELD + IDX_FIELD) break;
                x = window_top(LEN_FIELD + IDX_FIELD);
                window_drop(LEN_FIELD + IDX_FIELD);
                if ((x >> IDX_FIELD) > MAX_CODE_BITS) begin
                    r.block_done = 1'b1;
                    r.error = 1'b1;
                    outs.push_back(r);
                    close_block();
                    run = 1'b0;
                end else begin
                    code_len_max = x >> IDX_FIELD;
                    entries_left = x & 31;
                    stream_ph = PH_ZERO;
                end
            end else if (stream_ph == PH_ZERO) begin
                if (win_cnt < m + LEN_FIELD) break;
                x = window_top(m + LEN_FIELD);
                window_drop(m + LEN_FIELD);
                class_code[0] = x[12:0];
                entries_left = entries_left ? entries_left - 1 : 0;
                if (entries_left != 0) stream_ph = PH_ENTRY;
                else run = open_symbols();
            end else if (stream_ph == PH_ENTRY) begin
                if (win_cnt < IDX_FIELD + m + LEN_FIELD) break;
                x = window_top(IDX_FIELD + m + LEN_FIELD);
                window_drop(IDX_FIELD + m + LEN_FIELD);
                class_code[(x >> (m + LEN_FIELD)) & 31] = 13'(x & low_ones(m + LEN_FIELD));
                entries_left = entries_left ? entries_left - 1 : 0;
                if (entries_left == 0) run = open_symbols();
            end else if (stream_ph == PH_PREFIX) begin
                hh = (win_cnt < m) ? win_cnt : m;
                known = window_top(hh);
                sure = -1;
                may = -1;
                for (int c = 0; c < NUM_CLASSES; c++) begin
                    len = class_code[c] & 15;
                    code = class_code[c] >> LEN_FIELD;
                    if (len == 0 || len > m) continue;
                    if (len <= hh) begin
                        if ((known >> (hh - len)) == code) sure = c;
                    end else if ((code >> (len - hh)) == known) begin
                        may = c;
                    end
                end
                if (may > sure) break;
                if (sure < 0) begin
                    r.block_done = 1'b1;
                    r.error = 1'b1;
                    outs.push_back(r);
                    close_block();
                    run = 1'b0;
                end else begin
                    window_drop(class_code[sure] & 15);
                    if (sure == 0) begin
                        vals_left--;
                        if (vals_left == 0) begin
                            r.block_done = 1'b1;
                            close_block();
                            run = 1'b0;
                        end
                        outs.push_back(r);
                    end else begin
                        extra_class = sure;
                        stream_ph = PH_EXTRA;
                    end
                end
            end else begin
                need = (extra_class - 1) & 31;
                if (win_cnt < need) break;
                v = window_top(need) | (32'd1 << need);
                window_drop(need);
                stream_ph = PH_PREFIX;
                vals_left--;
                r.value = v[VALUE_BITS-1:0];
                if (vals_left == 0) begin
                    r.block_done = 1'b1;
                    close_block();
                    run = 1'b0;
                end
                outs.push_back(r);
            end
        end
        if (outs.size() > 0) outs[outs.size()-1].run_last = 1'b1;
        foreach (outs[i]) expected_q.push_back(outs[i]);
    endfunction

    // stimulus helpers
    function automatic void put_bits(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) stream_bits.push_back(v[i]);
    endfunction

    function automatic void put_word(input logic [31:0] w, input bit drain);
        word_q.push_back('{word: w, drain: drain});
    endfunction

    // pad the bit stream with random bits to whole words and queue them
    function automatic void flush_bits();
        logic [31:0] w;
        while (stream_bits.size() % 32 != 0) stream_bits.push_back(1'($urandom));
        while (stream_bits.size() > 0) begin
            for (int i = 31; i >= 0; i--) w[i] = stream_bits.pop_front();
            put_word(w, 1'b0);
        end
    endfunction

    // one block with a complete unary-shaped prefix code; optionally corrupted
    function automatic void gen_block(input int m, input int nvals, input int max_cls,
                                      input bit want_zero, input bit zero_heavy,
                                      input bit broken, input bit drain);
        int          perm [32];
        int          clen [10];
        logic [31:0] cval [10];
        int          nc, zi, nz, pick, j, t, pos;
        nc = $urandom_range(m + 1, 2);
        for (j = 0; j <= max_cls; j++) perm[j] = j;
        for (j = max_cls; j > 0; j--) begin
            pos = $urandom_range(j, 0);
            t = perm[j];
            perm[j] = perm[pos];
            perm[pos] = t;
        end
        if (want_zero) begin
            for (j = 0; j <= max_cls; j++) if (perm[j] == 0) pos = j;
            j = $urandom_range(nc - 1, 0);
            perm[pos] = perm[j];
            perm[j] = 0;
        end
        zi = -1;
        nz = 0;
        for (j = 0; j < nc; j++) begin
            clen[j] = (j < nc - 1) ? j + 1 : nc - 1;
            cval[j] = (j < nc - 1) ? 32'(9'(((1 << j) - 1) << 1))
                                   : 32'(9'((1 << (nc - 1)) - 1));
            if (perm[j] == 0) zi = j; else nz++;
        end
        put_word(nvals, drain);
        put_bits(m, 4);
        put_bits(nz + 1, 5);
        if (zi >= 0) begin
            put_bits(cval[zi], m);
            put_bits(clen[zi], 4);
        end else begin
            put_bits($urandom, m);
            put_bits(0, 4);
        end
        for (j = 0; j < nc; j++) begin
            if (j == zi) continue;
            put_bits(perm[j], 5);
            put_bits(cval[j], m);
            put_bits(clen[j], 4);
        end
        for (int k = 0; k < nvals; k++) begin
            if (zero_heavy && zi >= 0 && ($urandom % 8) != 0) pick = zi;
            else pick = $urandom_range(nc - 1, 0);
            put_bits(cval[pick], clen[pick]);
            if (perm[pick] > 1) put_bits($urandom, perm[pick] - 1);
        end
        if (broken && stream_bits.size() > 0) begin
            pos = $urandom_range(stream_bits.size() - 1, 0);
            stream_bits[pos] = ~stream_bits[pos];
        end
        flush_bits();
    endfunction

    // sender: bursts of random length with random gaps
    int send_burst = 0;
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.word <= '0;
        end else begin
            if (in_if.valid && in_if.ready) decode_word(in_if.word);
            if (in_if.valid && !in_if.ready) begin
                // hold the offered transaction
            end else if (send_gap > 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (word_q.size() == 0) begin
                in_if.valid <= 1'b0;
            end else if (word_q[0].drain && expected_q.size() != 0) begin
                in_if.valid <= 1'b0;
            end else begin
                in_if.valid <= 1'b1;
                in_if.word <= word_q[0].word;
                void'(word_q.pop_front());
                if (send_burst > 0) begin
                    send_burst--;
                end else begin
                    send_burst = $urandom_range(12, 0);
                    send_gap = ($urandom % 3 == 0) ? 0 : $urandom_range(40, 1);
                end
            end
        end
    end

    // receiver: stall pattern that steps through four modes, plus one long hold
    int rx_cycle = 0;
    int rx_hold = 0;
    bit rx_hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (res_cnt == 150 && !rx_hold_done) begin
                rx_hold_done = 1'b1;
                rx_hold = 4000;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                out_if.ready <= 1'b0;
            end else begin
                case ((rx_cycle / 64) % 4)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= 1'($urandom);
                    2: out_if.ready <= (rx_cycle % 4 == 0);
                    default: out_if.ready <= ($urandom % 8 != 0);
                endcase
            end
        end
    end

    // compare each result transaction with the oldest expectation
    t_result exp_r;
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            res_cnt++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: value=%0h run_last=%0b done=%0b err=%0b",
                         $realtime, out_if.value, out_if.run_last, out_if.block_done,
                         out_if.error);
                fail_cnt++;
            end else begin
                exp_r = expected_q.pop_front();
                if (exp_r.value !== out_if.value || exp_r.run_last !== out_if.run_last ||
                    exp_r.block_done !== out_if.block_done || exp_r.error !== out_if.error) begin
                    $display("%0t: mismatch: expected value=%0h run_last=%0b done=%0b err=%0b",
                             $realtime, exp_r.value, exp_r.run_last, exp_r.block_done,
                             exp_r.error);
                    $display("%0t:           actual   value=%0h run_last=%0b done=%0b err=%0b",
                             $realtime, out_if.value, out_if.run_last, out_if.block_done,
                             out_if.error);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog: count cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cnt = 0;
        end else if (i_rst_n) begin
            idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int m, sel;
        in_if.valid = 1'b0;
        in_if.word = '0;
        out_if.ready = 1'b0;
        for (int c = 0; c < NUM_CLASSES; c++) class_code[c] = '0;
        close_block();
        code_len_max = 0;

        // directed: header maximum above the limit, both extremes
        put_word(3, 1'b0);
        put_word({4'd10, 28'($urandom)}, 1'b0);
        put_word(32'hFFFF_FFFF, 1'b0);
        put_word(32'hFFFF_FFFF, 1'b0);
        // class count zero: only the zero entry, code 101 of length 3
        put_word(4, 1'b0);
        put_bits(3, 4);
        put_bits(0, 5);
        put_bits(32'b101, 3);
        put_bits(3, 4);
        for (int k = 0; k < 4; k++) put_bits(32'b101, 3);
        flush_bits();
        // count zero: block ends after its header
        gen_block(4, 0, 9, 1'b1, 1'b0, 1'b0, 1'b0);
        // one-bit codes, many zeros: hits the per-word result limit
        gen_block(1, 70, 31, 1'b1, 1'b1, 1'b0, 1'b1);
        // widest codes and the widest classes
        gen_block(9, 12, 31, 1'b0, 1'b0, 1'b0, 1'b0);
        gen_block(9, 10, 31, 1'b1, 1'b0, 1'b0, 1'b0);
        // a code miss ends the block with an error
        gen_block(3, 8, 9, 1'b1, 1'b0, 1'b1, 1'b1);
        put_word(0, 1'b0);
        put_word(32'h0000_0000, 1'b0);

        // random blocks, mostly well-formed
        while (word_q.size() < WORD_TARGET) begin
            sel = $urandom % 100;
            m = $urandom_range(9, 1);
            if (sel < 6) begin
                put_word($urandom_range(20, 1), 1'b0);
                put_word({4'($urandom_range(15, 10)), 28'($urandom)}, 1'b0);
            end else if (sel < 14) begin
                gen_block(m, $urandom_range(15, 1), 31, $urandom % 2, 1'b0, 1'b1, 1'b0);
            end else begin
                gen_block(m, $urandom_range(16, 0), ($urandom % 4 == 0) ? 31 : 11,
                          $urandom % 2, $urandom % 3 == 0, 1'b0, $urandom % 10 == 0);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all input, then all results, then let the block settle
        while (word_q.size() != 0 || in_if.valid) @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0 && expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
